FILE: rtl/thp_pkg.sv
`timescale 1ns / 1ps

package thp_pkg;

    localparam int TEMP_W = 12;

    // Sensor read failures at or above this count force a sensor fault
    localparam logic [7:0] FAIL_LIMIT = 8'd6;

    localparam logic [6:0] DUTY_OFF   = 7'd0;
    localparam logic [6:0] DUTY_WARN  = 7'd45;
    localparam logic [6:0] DUTY_LIMIT = 7'd80;
    localparam logic [6:0] DUTY_FAULT = 7'd100;

    // Configuration register indexes
    localparam logic [2:0] CFG_WARN_ENTER  = 3'd0;
    localparam logic [2:0] CFG_WARN_EXIT   = 3'd1;
    localparam logic [2:0] CFG_LIMIT_ENTER = 3'd2;
    localparam logic [2:0] CFG_LIMIT_EXIT  = 3'd3;
    localparam logic [2:0] CFG_FAULT_ENTER = 3'd4;
    localparam logic [2:0] CFG_FAULT_EXIT  = 3'd5;
    localparam logic [2:0] CFG_COLD_ENTER  = 3'd6;
    localparam logic [2:0] CFG_COLD_EXIT   = 3'd7;

    localparam logic [0:0] ACT_SAMPLE = 1'b0;
    localparam logic [0:0] ACT_CLEAR  = 1'b1;

    typedef enum logic [1:0] {
        ST_NORMAL = 2'd0,
        ST_WARN   = 2'd1,
        ST_LIMIT  = 2'd2,
        ST_FAULT  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        CA_NONE   = 2'd0,
        CA_HOT    = 2'd1,
        CA_COLD   = 2'd2,
        CA_SENSOR = 2'd3
    } cause_t;

    typedef logic signed [TEMP_W-1:0] temp_t;

    typedef struct packed {
        temp_t warn_enter;
        temp_t warn_exit;
        temp_t limit_enter;
        temp_t limit_exit;
        temp_t fault_enter;
        temp_t fault_exit;
        temp_t cold_enter;
        temp_t cold_exit;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        warn_enter:  12'sd400,
        warn_exit:   12'sd370,
        limit_enter: 12'sd500,
        limit_exit:  12'sd470,
        fault_enter: 12'sd550,
        fault_exit:  12'sd500,
        cold_enter:  12'sd0,
        cold_exit:   12'sd30
    };

    typedef struct packed {
        logic       action;
        logic       sensor_valid;
        logic [7:0] read_fails;
        temp_t      probe_a_temp;
        temp_t      probe_b_temp;
        temp_t      die_temp_in;
    } item_t;

    typedef struct packed {
        mode_t  mode;
        cause_t cause;
        logic   fault_latch;
        logic   sensor_good;
        temp_t  hottest;
        temp_t  coldest;
        temp_t  die;
    } state_t;

    typedef struct packed {
        mode_t      thermal_state;
        cause_t     cause;
        logic [6:0] fan_duty;
        logic       chg_block;
        logic       dsg_block;
        logic       sensor_good;
        temp_t      hottest;
        temp_t      coldest;
        temp_t      die_temp_out;
        logic       clear_done;
    } result_t;

endpackage

FILE: rtl/thp_core.sv
`timescale 1ns / 1ps

module thp_core (
    input  thp_pkg::cfg_t    cfg,
    input  thp_pkg::state_t  state_cur,
    input  thp_pkg::item_t   item,
    output thp_pkg::state_t  state_next,
    output thp_pkg::result_t res_next
);
    import thp_pkg::*;

    function automatic mode_t hot_band(input temp_t t, input mode_t prev, input cfg_t c);
        mode_t m;
        if (t >= c.fault_enter) begin
            m = ST_FAULT;
        end else if (prev == ST_FAULT) begin
            m = ST_FAULT;
        end else if (t >= c.limit_enter) begin
            m = ST_LIMIT;
        end else if (prev == ST_LIMIT && t > c.limit_exit) begin
            m = ST_LIMIT;
        end else if (t >= c.warn_enter) begin
            m = ST_WARN;
        end else if (prev == ST_WARN && t > c.warn_exit) begin
            m = ST_WARN;
        end else begin
            m = ST_NORMAL;
        end
        return m;
    endfunction

    always_comb begin
        state_t st;
        mode_t  nxt;
        temp_t  hot;
        temp_t  cold;
        logic   bad;
        logic   cleared;

        st      = state_cur;
        cleared = 1'b0;
        hot     = (item.probe_a_temp > item.probe_b_temp) ? item.probe_a_temp
                                                          : item.probe_b_temp;
        cold    = (item.probe_a_temp < item.probe_b_temp) ? item.probe_a_temp
                                                          : item.probe_b_temp;
        bad     = !item.sensor_valid || (item.read_fails >= FAIL_LIMIT);
        nxt     = ST_NORMAL;

        if (item.action == ACT_CLEAR) begin
            if (st.mode == ST_FAULT && st.sensor_good && st.hottest <= cfg.fault_exit
                    && st.cause != CA_SENSOR) begin
                cleared        = 1'b1;
                st.fault_latch = 1'b0;
                st.mode        = hot_band(st.hottest, ST_LIMIT, cfg);
                if (st.coldest < cfg.cold_enter) begin
                    st.mode  = ST_LIMIT;
                    st.cause = CA_COLD;
                end else if (st.mode == ST_NORMAL) begin
                    st.cause = CA_NONE;
                end else begin
                    st.cause = CA_HOT;
                end
            end
        end else if (bad) begin
            // Keep the stored temperatures
            st.sensor_good = 1'b0;
            st.mode        = ST_FAULT;
            st.cause       = CA_SENSOR;
            st.fault_latch = 1'b1;
        end else begin
            st.sensor_good = 1'b1;
            st.hottest     = hot;
            st.coldest     = cold;
            st.die         = item.die_temp_in;
            // A good sample recovers from a sensor fault on its own
            if (st.fault_latch && st.cause == CA_SENSOR) begin
                st.fault_latch = 1'b0;
                st.mode        = ST_NORMAL;
                st.cause       = CA_NONE;
            end
            nxt = hot_band(hot, st.mode, cfg);
            if (nxt == ST_FAULT) begin
                st.fault_latch = 1'b1;
                st.cause       = CA_HOT;
            end else if (cold < cfg.cold_enter
                         || (st.cause == CA_COLD && cold < cfg.cold_exit)) begin
                if (nxt == ST_NORMAL || nxt == ST_WARN) begin
                    nxt = ST_LIMIT;
                end
                st.cause = CA_COLD;
            end else if (nxt == ST_NORMAL) begin
                st.cause = CA_NONE;
            end else begin
                st.cause = CA_HOT;
            end
            if (st.fault_latch && st.cause == CA_HOT) begin
                nxt = ST_FAULT;
            end
            st.mode = nxt;
        end

        state_next = st;

        res_next.thermal_state = st.mode;
        res_next.cause         = st.cause;
        res_next.sensor_good   = st.sensor_good;
        res_next.hottest       = st.hottest;
        res_next.coldest       = st.coldest;
        res_next.die_temp_out  = st.die;
        res_next.clear_done    = cleared;
        case (st.mode)
            ST_WARN: begin
                res_next.fan_duty  = DUTY_WARN;
                res_next.chg_block = 1'b0;
                res_next.dsg_block = 1'b0;
            end
            ST_LIMIT: begin
                res_next.fan_duty  = (st.cause == CA_COLD) ? DUTY_OFF : DUTY_LIMIT;
                res_next.chg_block = 1'b1;
                res_next.dsg_block = 1'b0;
            end
            ST_FAULT: begin
                res_next.fan_duty  = DUTY_FAULT;
                res_next.chg_block = 1'b1;
                res_next.dsg_block = 1'b1;
            end
            default: begin
                res_next.fan_duty  = DUTY_OFF;
                res_next.chg_block = 1'b0;
                res_next.dsg_block = 1'b0;
            end
        endcase
    end

endmodule

FILE: rtl/thermal_hysteresis_policy.sv
`timescale 1ns / 1ps

// Battery thermal policy.
// Slave stream: one item per transfer. s_tuser carries the action (sample or
// clear-fault request); s_tdata carries the sensor reading.
// Master stream: one result per item, in order, with the band, cause, fan duty,
// FET-off flags, stored temperatures and the clear outcome.
// Configuration channel: cfg_index selects one of eight 12-bit thresholds,
// cfg_data is the value; cfg_ready is always high. Write only while idle.
// Path: an accepted item passes the input register, then the result register,
// where m_tvalid rises. Throughput: one item per cycle while m_tready is high;
// the whole policy update is a single pass of compares between the two
// registers, and the policy state is written as the item moves into the result
// register.
// Reset (aresetn low, synchronous): thresholds return to their defaults, the
// band is NORMAL with no cause, no fault latched, stored temperatures zero,
// both stages empty.
// Receiver stall: the result register holds, the input register can still take
// one item, then s_tready falls until m_tready returns.
module thermal_hysteresis_policy (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [0] sensor_valid, [8:1] read_fails, [20:9] probe_a_temp,
    // [32:21] probe_b_temp, [44:33] die_temp_in, [47:45] zero
    input  logic [47:0] s_tdata,
    // [0] action
    input  logic [0:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [1:0] thermal_state, [3:2] cause, [10:4] fan_duty, [11] chg_block,
    // [12] dsg_block, [13] sensor_good, [25:14] hottest, [37:26] coldest,
    // [49:38] die_temp_out, [50] clear_done, [55:51] zero
    output logic [55:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [11:0] cfg_data
);
    import thp_pkg::*;

    cfg_t    cfg_reg;
    state_t  state_reg;
    state_t  state_next;
    item_t   item_reg;
    logic    in_valid_reg;
    result_t res_reg;
    result_t res_next;
    logic    out_valid_reg;
    logic    out_adv;
    logic    in_adv;

    assign cfg_ready = 1'b1;
    assign out_adv   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || out_adv;
    assign in_adv    = s_tvalid && s_tready;
    assign m_tvalid  = out_valid_reg;

    assign m_tdata = {5'd0, res_reg.clear_done, res_reg.die_temp_out, res_reg.coldest,
                      res_reg.hottest, res_reg.sensor_good, res_reg.dsg_block,
                      res_reg.chg_block, res_reg.fan_duty, res_reg.cause,
                      res_reg.thermal_state};

    thp_core u_core (
        .cfg        (cfg_reg),
        .state_cur  (state_reg),
        .item       (item_reg),
        .state_next (state_next),
        .res_next   (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_WARN_ENTER:  cfg_reg.warn_enter  <= cfg_data;
                CFG_WARN_EXIT:   cfg_reg.warn_exit   <= cfg_data;
                CFG_LIMIT_ENTER: cfg_reg.limit_enter <= cfg_data;
                CFG_LIMIT_EXIT:  cfg_reg.limit_exit  <= cfg_data;
                CFG_FAULT_ENTER: cfg_reg.fault_enter <= cfg_data;
                CFG_FAULT_EXIT:  cfg_reg.fault_exit  <= cfg_data;
                CFG_COLD_ENTER:  cfg_reg.cold_enter  <= cfg_data;
                CFG_COLD_EXIT:   cfg_reg.cold_exit   <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_adv) begin
            item_reg.action       <= s_tuser[0];
            item_reg.sensor_valid <= s_tdata[0];
            item_reg.read_fails   <= s_tdata[8:1];
            item_reg.probe_a_temp <= s_tdata[20:9];
            item_reg.probe_b_temp <= s_tdata[32:21];
            item_reg.die_temp_in  <= s_tdata[44:33];
        end
    end

    // Policy state and result stage advance together
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= '{mode: ST_NORMAL, cause: CA_NONE, fault_latch: 1'b0,
                               sensor_good: 1'b0, hottest: '0, coldest: '0, die: '0};
            out_valid_reg <= 1'b0;
        end else begin
            if (out_adv) begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_adv) begin
            res_reg <= res_next;
        end
    end

    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !out_adv |=> $stable(state_reg))
        else $error("policy state changed without an item");

    a_hot_latch_fault: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.fault_latch && state_reg.cause == CA_HOT) |-> state_reg.mode == ST_FAULT)
        else $error("hot fault latched outside FAULT");

    a_sensor_fault: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && res_reg.cause == CA_SENSOR)
            |-> (res_reg.thermal_state == ST_FAULT && !res_reg.sensor_good))
        else $error("sensor cause without sensor fault");

    a_dsg_fault: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && res_reg.dsg_block) |-> res_reg.thermal_state == ST_FAULT)
        else $error("discharge off outside FAULT");

    a_clear_good: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && res_reg.clear_done)
            |-> (res_reg.sensor_good && !state_reg.fault_latch))
        else $error("clear reported with bad sensor or fault still latched");

endmodule

FILE: tb/thermal_hysteresis_policy_tb.sv
`timescale 1ns / 1ps

module thermal_hysteresis_policy_tb;
    import thp_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    // [0] sensor_valid, [8:1] read_fails, [20:9] probe_a_temp,
    // [32:21] probe_b_temp, [44:33] die_temp_in, [47:45] zero
    logic [47:0] s_tdata;
    // [0] action
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    // [1:0] thermal_state, [3:2] cause, [10:4] fan_duty, [11] chg_block,
    // [12] dsg_block, [13] sensor_good, [25:14] hottest, [37:26] coldest,
    // [49:38] die_temp_out, [50] clear_done, [55:51] zero
    logic [55:0] m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [11:0] cfg_data;

    thermal_hysteresis_policy u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 aclk = ~aclk;

    // Policy mirror: thresholds and state as the block should hold them
    temp_t  thr [8];
    temp_t  new_thr [8];
    mode_t  p_mode;
    cause_t p_cause;
    logic   p_latch;
    logic   p_sensor_good;
    temp_t  p_hottest;
    temp_t  p_coldest;
    temp_t  p_die;

    result_t expected_status [$];
    int      mismatches;
    bit      tx_idle_en;
    bit      rx_idle_en;
    int      walk_level;

    function automatic temp_t clamp_temp(int v);
        if (v > 2047) return 12'sd2047;
        if (v < -2048) return -12'sd2048;
        return temp_t'(v);
    endfunction

    function automatic mode_t hot_band(temp_t t, mode_t prev);
        if (t >= thr[CFG_FAULT_ENTER]) return ST_FAULT;
        if (prev == ST_FAULT) return ST_FAULT;
        if (t >= thr[CFG_LIMIT_ENTER]) return ST_LIMIT;
        if (prev == ST_LIMIT && t > thr[CFG_LIMIT_EXIT]) return ST_LIMIT;
        if (t >= thr[CFG_WARN_ENTER]) return ST_WARN;
        if (prev == ST_WARN && t > thr[CFG_WARN_EXIT]) return ST_WARN;
        return ST_NORMAL;
    endfunction

    // Advance the mirrored policy by one item and return the status it reports
    function automatic result_t update_policy(item_t it);
        result_t r;
        mode_t   next;
        temp_t   a;
        temp_t   b;
        logic    cleared;
        cleared = 1'b0;
        a = it.probe_a_temp;
        b = it.probe_b_temp;
        if (it.action == ACT_CLEAR) begin
            if (p_mode == ST_FAULT && p_sensor_good && !(p_hottest > thr[CFG_FAULT_EXIT])
                    && p_cause != CA_SENSOR) begin
                cleared = 1'b1;
                p_latch = 1'b0;
                p_mode = hot_band(p_hottest, ST_LIMIT);
                if (p_coldest < thr[CFG_COLD_ENTER]) begin
                    p_mode = ST_LIMIT;
                    p_cause = CA_COLD;
                end else if (p_mode == ST_NORMAL) begin
                    p_cause = CA_NONE;
                end else begin
                    p_cause = CA_HOT;
                end
            end
        end else if (!it.sensor_valid || it.read_fails >= FAIL_LIMIT) begin
            // stored temperatures are kept on a bad read
            p_sensor_good = 1'b0;
            p_mode = ST_FAULT;
            p_cause = CA_SENSOR;
            p_latch = 1'b1;
        end else begin
            p_sensor_good = 1'b1;
            p_die = it.die_temp_in;
            p_hottest = (a > b) ? a : b;
            p_coldest = (a < b) ? a : b;
            if (p_latch && p_cause == CA_SENSOR) begin
                p_latch = 1'b0;
                p_mode = ST_NORMAL;
                p_cause = CA_NONE;
            end
            next = hot_band(p_hottest, p_mode);
            if (next == ST_FAULT) begin
                p_latch = 1'b1;
                p_cause = CA_HOT;
            end else if (p_coldest < thr[CFG_COLD_ENTER] ||
                         (p_cause == CA_COLD && p_coldest < thr[CFG_COLD_EXIT])) begin
                if (next == ST_NORMAL || next == ST_WARN) next = ST_LIMIT;
                p_cause = CA_COLD;
            end else if (next == ST_NORMAL) begin
                p_cause = CA_NONE;
            end else begin
                p_cause = CA_HOT;
            end
            if (p_latch && p_cause == CA_HOT) next = ST_FAULT;
            p_mode = next;
        end

        r.thermal_state = p_mode;
        r.cause         = p_cause;
        r.fan_duty      = DUTY_OFF;
        r.chg_block     = 1'b0;
        r.dsg_block     = 1'b0;
        case (p_mode)
            ST_WARN: begin
                r.fan_duty = DUTY_WARN;
            end
            ST_LIMIT: begin
                r.fan_duty = (p_cause == CA_COLD) ? DUTY_OFF : DUTY_LIMIT;
                r.chg_block = 1'b1;
            end
            ST_FAULT: begin
                r.fan_duty = DUTY_FAULT;
                r.chg_block = 1'b1;
                r.dsg_block = 1'b1;
            end
            default: begin
            end
        endcase
        r.sensor_good  = p_sensor_good;
        r.hottest      = p_hottest;
        r.coldest      = p_coldest;
        r.die_temp_out = p_die;
        r.clear_done   = cleared;
        return r;
    endfunction

    // Entered and left at a falling edge; s_tvalid stays high for a back-to-back item
    task automatic send_item(item_t it);
        while (tx_idle_en && $urandom_range(99) < 21) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.action;
        s_tdata  <= {3'b000, it.die_temp_in, it.probe_b_temp, it.probe_a_temp,
                     it.read_fails, it.sensor_valid};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_status.push_back(update_policy(it));
        @(negedge aclk);
    endtask

    task automatic send_sample(logic valid, logic [7:0] fails, int a, int b, int die);
        item_t it;
        it.action       = ACT_SAMPLE;
        it.sensor_valid = valid;
        it.read_fails   = fails;
        it.probe_a_temp = clamp_temp(a);
        it.probe_b_temp = clamp_temp(b);
        it.die_temp_in  = clamp_temp(die);
        send_item(it);
    endtask

    // The reading fields of a clear request carry noise
    task automatic send_clear();
        item_t it;
        it = item_t'({$urandom, $urandom});
        it.action = ACT_CLEAR;
        send_item(it);
    endtask

    task automatic wait_until_drained();
        s_tvalid <= 1'b0;
        while (expected_status.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // Write all eight thresholds from new_thr; call only when drained
    task automatic write_thresholds();
        for (int i = 0; i < 8; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= 3'(i);
            cfg_data  <= new_thr[i];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            thr[i] = new_thr[i];
            @(negedge aclk);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic pick_ordered_thresholds();
        int we;
        int le;
        int fe;
        int ce;
        we = int'($urandom_range(1600)) - 600;
        le = we + int'($urandom_range(200));
        fe = le + int'($urandom_range(200));
        ce = we - 200 - int'($urandom_range(300));
        new_thr[CFG_WARN_ENTER]  = clamp_temp(we);
        new_thr[CFG_WARN_EXIT]   = clamp_temp(we - int'($urandom_range(60)));
        new_thr[CFG_LIMIT_ENTER] = clamp_temp(le);
        new_thr[CFG_LIMIT_EXIT]  = clamp_temp(le - int'($urandom_range(60)));
        new_thr[CFG_FAULT_ENTER] = clamp_temp(fe);
        new_thr[CFG_FAULT_EXIT]  = clamp_temp(fe - int'($urandom_range(100)));
        new_thr[CFG_COLD_ENTER]  = clamp_temp(ce);
        new_thr[CFG_COLD_EXIT]   = clamp_temp(ce + int'($urandom_range(60)));
    endtask

    function automatic temp_t near_threshold();
        return clamp_temp(int'(thr[3'($urandom_range(7))]) + int'($urandom_range(80)) - 40);
    endfunction

    // Mostly a slow temperature walk across the bands, so hysteresis and
    // latched faults are reached; the rest is near-threshold values and noise
    function automatic item_t random_item();
        item_t it;
        int    pick;
        int    top;
        int    bottom;
        temp_t swap;
        top = -2048;
        bottom = 2047;
        foreach (thr[i]) begin
            if (thr[i] > top) top = thr[i];
            if (thr[i] < bottom) bottom = thr[i];
        end
        walk_level += int'($urandom_range(60)) - 30;
        if (walk_level > top + 80) walk_level = top + 80 - int'($urandom_range(40));
        if (walk_level < bottom - 80) walk_level = bottom - 80 + int'($urandom_range(40));

        it.action = ($urandom_range(99) < 12) ? ACT_CLEAR : ACT_SAMPLE;
        it.sensor_valid = ($urandom_range(99) >= 5);
        pick = $urandom_range(99);
        if (pick < 85) it.read_fails = 8'($urandom_range(5));
        else if (pick < 93) it.read_fails = 8'($urandom_range(7, 6));
        else it.read_fails = 8'($urandom);
        pick = $urandom_range(99);
        if (pick < 60) begin
            it.probe_a_temp = clamp_temp(walk_level + int'($urandom_range(20)) - 10);
            it.probe_b_temp = clamp_temp(walk_level - int'($urandom_range(60)));
        end else if (pick < 85) begin
            it.probe_a_temp = near_threshold();
            it.probe_b_temp = near_threshold();
        end else begin
            it.probe_a_temp = 12'($urandom);
            it.probe_b_temp = 12'($urandom);
        end
        if ($urandom_range(1) == 1) begin
            swap = it.probe_a_temp;
            it.probe_a_temp = it.probe_b_temp;
            it.probe_b_temp = swap;
        end
        it.die_temp_in = 12'($urandom);
        return it;
    endfunction

    always @(negedge aclk) begin
        m_tready <= !rx_idle_en || ($urandom_range(99) >= 21);
    end

    function automatic void check_field(string name, logic [11:0] want, logic [11:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t ns: %s mismatch, expected 0x%03h, actual 0x%03h",
                     $time, name, want, got);
        end
    endfunction

    always @(posedge aclk) begin : status_check
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_status.size() == 0) begin
                mismatches++;
                $display("%0t ns: unexpected result, expected none, actual 0x%014h",
                         $time, m_tdata);
            end else begin
                want = expected_status.pop_front();
                check_field("thermal_state", 12'(want.thermal_state), 12'(m_tdata[1:0]));
                check_field("cause", 12'(want.cause), 12'(m_tdata[3:2]));
                check_field("fan_duty", 12'(want.fan_duty), 12'(m_tdata[10:4]));
                check_field("chg_block", 12'(want.chg_block), 12'(m_tdata[11]));
                check_field("dsg_block", 12'(want.dsg_block), 12'(m_tdata[12]));
                check_field("sensor_good", 12'(want.sensor_good), 12'(m_tdata[13]));
                check_field("hottest", want.hottest, m_tdata[25:14]);
                check_field("coldest", want.coldest, m_tdata[37:26]);
                check_field("die_temp_out", want.die_temp_out, m_tdata[49:38]);
                check_field("clear_done", 12'(want.clear_done), 12'(m_tdata[50]));
            end
        end
    end

    // Default thresholds: warn 400/370, limit 500/470, fault 550/500
    task automatic test_hot_bands();
        send_clear();                            // nothing latched, refused
        send_sample(1'b1, 8'd0, 250, 200, 300);
        send_sample(1'b1, 8'd0, 400, 100, 310);  // warn at the enter point
        send_sample(1'b1, 8'd0, 371, 380, 320);  // warn held above exit
        send_sample(1'b1, 8'd0, 370, 0, 330);    // back to normal at exit
        send_sample(1'b1, 8'd0, 500, 100, 340);
        send_sample(1'b1, 8'd0, 471, 100, 350);  // limit held
        send_sample(1'b1, 8'd0, 470, 0, 360);    // drop to warn
        send_sample(1'b1, 8'd0, 550, 100, 370);  // hot fault latches
        send_sample(1'b1, 8'd0, 501, 100, 380);
        send_clear();                            // too hot to clear
        send_sample(1'b1, 8'd0, 2047, -2048, 2047);
        send_sample(1'b1, 8'd0, 500, 100, -2048);
        send_clear();                            // cleared into limit
    endtask

    task automatic test_sensor_faults();
        send_sample(1'b0, 8'd0, 900, 900, 900);  // invalid read, temperatures kept
        send_clear();                            // sensor cause cannot be cleared
        send_sample(1'b1, 8'd5, 100, 50, 120);   // recovers on its own
        send_sample(1'b1, FAIL_LIMIT, 100, 50, 120);
        send_sample(1'b1, 8'd255, -300, 700, 0);
    endtask

    // Default cold thresholds: enter below 0, held below 30
    task automatic test_cold_inhibit();
        send_sample(1'b1, 8'd0, -1, 200, 10);
        send_sample(1'b1, 8'd0, 29, 200, 20);
        send_sample(1'b1, 8'd0, 30, 200, 30);
        send_sample(1'b1, 8'd0, -2048, -2048, -2048);
        send_sample(1'b1, 8'd0, 600, -100, 40);  // hot fault wins over cold
        send_clear();
        send_sample(1'b1, 8'd0, 100, -100, 50);
        send_clear();                            // cleared into cold limit
    endtask

    task automatic run_random(int count);
        repeat (count) send_item(random_item());
    endtask

    task automatic test_threshold_extremes();
        wait_until_drained();
        foreach (new_thr[i]) new_thr[i] = -12'sd2048;
        write_thresholds();
        run_random(50);

        wait_until_drained();
        foreach (new_thr[i]) new_thr[i] = 12'sd2047;
        write_thresholds();
        run_random(50);

        // inverted bands: applied literally, fault checked first
        wait_until_drained();
        new_thr[CFG_WARN_ENTER]  = 12'sd600;
        new_thr[CFG_WARN_EXIT]   = 12'sd900;
        new_thr[CFG_LIMIT_ENTER] = 12'sd300;
        new_thr[CFG_LIMIT_EXIT]  = 12'sd700;
        new_thr[CFG_FAULT_ENTER] = 12'sd100;
        new_thr[CFG_FAULT_EXIT]  = 12'sd800;
        new_thr[CFG_COLD_ENTER]  = 12'sd200;
        new_thr[CFG_COLD_EXIT]   = -12'sd200;
        write_thresholds();
        run_random(50);

        wait_until_drained();
        foreach (new_thr[i]) new_thr[i] = 12'($urandom);
        write_thresholds();
        run_random(50);

        wait_until_drained();
        pick_ordered_thresholds();
        write_thresholds();
        run_random(50);
    endtask

    task automatic test_random_policy();
        wait_until_drained();
        pick_ordered_thresholds();
        write_thresholds();
        run_random(500);

        // hold the sender until every status has come back
        wait_until_drained();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        run_random(250);
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;

        wait_until_drained();
        pick_ordered_thresholds();
        write_thresholds();
        run_random(500);
    endtask

    initial begin
        #2000000;
        $display("thermal_hysteresis_policy test failed");
        $finish;
    end

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = ACT_SAMPLE;
        cfg_valid = 1'b0;
        cfg_index = CFG_WARN_ENTER;
        cfg_data  = '0;
        mismatches = 0;
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        walk_level = 300;
        thr[CFG_WARN_ENTER]  = CFG_RESET.warn_enter;
        thr[CFG_WARN_EXIT]   = CFG_RESET.warn_exit;
        thr[CFG_LIMIT_ENTER] = CFG_RESET.limit_enter;
        thr[CFG_LIMIT_EXIT]  = CFG_RESET.limit_exit;
        thr[CFG_FAULT_ENTER] = CFG_RESET.fault_enter;
        thr[CFG_FAULT_EXIT]  = CFG_RESET.fault_exit;
        thr[CFG_COLD_ENTER]  = CFG_RESET.cold_enter;
        thr[CFG_COLD_EXIT]   = CFG_RESET.cold_exit;
        p_mode        = ST_NORMAL;
        p_cause       = CA_NONE;
        p_latch       = 1'b0;
        p_sensor_good = 1'b0;
        p_hottest     = '0;
        p_coldest     = '0;
        p_die         = '0;

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_hot_bands();
        test_sensor_faults();
        test_cold_inhibit();
        test_threshold_extremes();
        test_random_policy();

        wait_until_drained();
        repeat (8) @(negedge aclk);
        if (mismatches == 0) begin
            $display("thermal_hysteresis_policy test passed");
        end else begin
            $display("thermal_hysteresis_policy test failed");
        end
        $finish;
    end

endmodule
